[sv/kef_pkg.sv]
// ----------------------------------------------------------------------------
// kef_pkg
// Shared constants, types and the scancode-to-game-key table of the key
// event filter with event FIFO.
// ----------------------------------------------------------------------------
package kef_pkg;

  // Number of FIFO slots; one slot always stays empty.
  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // Scancode layout: bit 7 marks a release, bits 6..0 name the key.
  localparam int SC_W       = 8;
  localparam int KEY_IDX_W  = 7;
  localparam int KEY_COUNT  = 1 << KEY_IDX_W;
  localparam int KEY_W      = 8;
  localparam int EVENT_W    = KEY_W + 1;

  localparam logic [SC_W-1:0]  SC_NONE = '0;
  localparam logic [KEY_W-1:0] KC_NONE = '0;

  // Game key codes.
  localparam logic [KEY_W-1:0] KC_RIGHT  = 8'hAE;
  localparam logic [KEY_W-1:0] KC_LEFT   = 8'hAC;
  localparam logic [KEY_W-1:0] KC_UP     = 8'hAD;
  localparam logic [KEY_W-1:0] KC_DOWN   = 8'hAF;
  localparam logic [KEY_W-1:0] KC_STRL   = 8'hA0;
  localparam logic [KEY_W-1:0] KC_STRR   = 8'hA1;
  localparam logic [KEY_W-1:0] KC_USE    = 8'hA2;
  localparam logic [KEY_W-1:0] KC_FIRE   = 8'hA3;
  localparam logic [KEY_W-1:0] KC_ESC    = 8'h1B;
  localparam logic [KEY_W-1:0] KC_ENTER  = 8'h0D;
  localparam logic [KEY_W-1:0] KC_TAB    = 8'h09;
  localparam logic [KEY_W-1:0] KC_BKSP   = 8'h7F;
  localparam logic [KEY_W-1:0] KC_MINUS  = 8'h2D;
  localparam logic [KEY_W-1:0] KC_EQUALS = 8'h3D;
  localparam logic [KEY_W-1:0] KC_RSHIFT = 8'hB6;
  localparam logic [KEY_W-1:0] KC_RALT   = 8'hB8;
  localparam logic [KEY_W-1:0] KC_F1     = 8'hBB;

  // Action codes of an input transfer.
  typedef enum logic {
    ACT_SCANCODE = 1'b0,
    ACT_POP      = 1'b1
  } kef_action_e;

  // Result item as held in the output register.
  typedef struct packed {
    logic             event_queued;
    logic             event_dropped;
    logic             avail;
    logic             out_pressed;
    logic [KEY_W-1:0] out_key;
  } kef_result_t;

  // Maps a key index to its game key code; unmapped keys give KC_NONE.
  function automatic logic [KEY_W-1:0] key_map(input logic [KEY_IDX_W-1:0] idx);
    logic [KEY_W-1:0] kc;
    kc = KC_NONE;
    unique case (idx)
      7'h48, 7'h11: kc = KC_UP;
      7'h50, 7'h1F: kc = KC_DOWN;
      7'h4B:        kc = KC_LEFT;
      7'h4D:        kc = KC_RIGHT;
      7'h1D, 7'h12: kc = KC_FIRE;
      7'h38:        kc = KC_RALT;
      7'h39, 7'h21: kc = KC_USE;
      7'h2A, 7'h36: kc = KC_RSHIFT;
      7'h1E:        kc = KC_STRL;
      7'h20:        kc = KC_STRR;
      7'h01:        kc = KC_ESC;
      7'h1C:        kc = KC_ENTER;
      7'h0F:        kc = KC_TAB;
      7'h0E:        kc = KC_BKSP;
      7'h02:        kc = 8'h31;
      7'h03:        kc = 8'h32;
      7'h04:        kc = 8'h33;
      7'h05:        kc = 8'h34;
      7'h06:        kc = 8'h35;
      7'h07:        kc = 8'h36;
      7'h08:        kc = 8'h37;
      7'h09:        kc = 8'h38;
      7'h0A:        kc = 8'h39;
      7'h3B:        kc = KC_F1;
      7'h3C:        kc = KC_F1 + 8'd1;
      7'h3D:        kc = KC_F1 + 8'd2;
      7'h3E:        kc = KC_F1 + 8'd3;
      7'h3F:        kc = KC_F1 + 8'd4;
      7'h40:        kc = KC_F1 + 8'd5;
      7'h41:        kc = KC_F1 + 8'd6;
      7'h42:        kc = KC_F1 + 8'd7;
      7'h43:        kc = KC_F1 + 8'd8;
      7'h44:        kc = KC_F1 + 8'd9;
      7'h57:        kc = 8'hD7;
      7'h58:        kc = 8'hD8;
      7'h0C:        kc = KC_MINUS;
      7'h0D:        kc = KC_EQUALS;
      7'h19:        kc = 8'h70;
      7'h32:        kc = 8'h6D;
      7'h15:        kc = 8'h79;
      7'h31:        kc = 8'h6E;
      7'h14:        kc = 8'h74;
      default:      kc = KC_NONE;
    endcase
    return kc;
  endfunction

endpackage

[sv/kef_if.sv]
// ----------------------------------------------------------------------------
// kef_if
// Valid/ready channels of the key event filter: the request channel and
// the result channel.
// ----------------------------------------------------------------------------
interface kef_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [kef_pkg::SC_W-1:0] scancode;

  modport source (output valid, output action, output scancode, input ready);
  modport sink   (input valid, input action, input scancode, output ready);
endinterface

interface kef_out_if;
  logic                      valid;
  logic                      ready;
  logic                      event_queued;
  logic                      event_dropped;
  logic                      avail;
  logic                      out_pressed;
  logic [kef_pkg::KEY_W-1:0] out_key;

  modport source (output valid, output event_queued, output event_dropped,
                  output avail, output out_pressed, output out_key, input ready);
  modport sink   (input valid, input event_queued, input event_dropped,
                  input avail, input out_pressed, input out_key, output ready);
endinterface

[sv/kef_ram.sv]
// ----------------------------------------------------------------------------
// kef_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module kef_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/key_event_filter_fifo.sv]
// ----------------------------------------------------------------------------
// key_event_filter_fifo
// Filters PS/2 set-1 scancodes into game key events and queues them in a
// FIFO; a pop request returns the oldest queued event.
// ----------------------------------------------------------------------------
// A request is accepted and its memories are read at acceptance; its result
// is written to the output register while the request is in flight. A new
// request is not accepted while one is in flight, as the held-key memory
// and the event memory are read at acceptance and written back while the
// request is in flight. rst_ni clears the held-key valid bits, both FIFO
// pointers and all control flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_event_filter_fifo (
  input  logic     clk_i,
  input  logic     rst_ni,
  kef_in_if.sink   in_i,
  kef_out_if.source out_o
);
  import kef_pkg::*;

  // --------------------------------------------------------------------------
  // Request stage. A transfer is taken only while no request is in flight and
  // the output register is empty or being emptied in the same cycle, so the
  // result of the request always finds a free output register.
  // --------------------------------------------------------------------------
  logic                 busy_q;
  logic                 out_valid_q;
  kef_result_t          out_q, out_d;
  logic                 act_q;
  logic [SC_W-1:0]      sc_q;
  logic [PTR_W-1:0]     wp_q, wp_d;
  logic [PTR_W-1:0]     rp_q, rp_d;
  logic [KEY_COUNT-1:0] held_vld_q;

  logic in_xfer;
  logic out_xfer;

  assign in_i.ready = !busy_q && (!out_valid_q || out_o.ready);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= in_i.action;
      sc_q  <= in_i.scancode;
    end
  end

  // --------------------------------------------------------------------------
  // Memories. The held-key memory is read at the key index of the incoming
  // scancode and the event memory at the read pointer, both at acceptance.
  // Since only one request is in flight, the write-back of one request always
  // lands before the read of the next one, so no forwarding is required.
  // --------------------------------------------------------------------------
  logic                 held_rdata;
  logic                 held_we;
  logic                 ev_we;
  logic [EVENT_W-1:0]   ev_rdata;
  logic [EVENT_W-1:0]   ev_wdata;
  logic [KEY_IDX_W-1:0] base;
  logic                 pressed;
  logic                 held;
  logic [KEY_W-1:0]     key;
  logic [PTR_W-1:0]     wp_next, rp_next;

  kef_ram #(
    .Width (1),
    .Depth (KEY_COUNT)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .waddr_i (base),
    .wdata_i (pressed),
    .re_i    (in_xfer),
    .raddr_i (in_i.scancode[KEY_IDX_W-1:0]),
    .rdata_o (held_rdata)
  );

  kef_ram #(
    .Width (EVENT_W),
    .Depth (QUEUE_DEPTH)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (wp_q),
    .wdata_i (ev_wdata),
    .re_i    (in_xfer),
    .raddr_i (rp_q),
    .rdata_o (ev_rdata)
  );

  // --------------------------------------------------------------------------
  // Completion. A key whose valid bit is clear has never been written since
  // reset and reads as not held. The pointers wrap explicitly so that any
  // queue depth works, not only powers of two.
  // --------------------------------------------------------------------------
  assign base     = sc_q[KEY_IDX_W-1:0];
  assign pressed  = !sc_q[SC_W-1];
  assign held     = held_vld_q[base] && held_rdata;
  assign key      = key_map(base);
  assign wp_next  = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign rp_next  = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
  assign ev_wdata = {pressed, key};

  always_comb begin
    out_d   = '0;
    held_we = 1'b0;
    ev_we   = 1'b0;
    wp_d    = wp_q;
    rp_d    = rp_q;
    if (busy_q) begin
      unique case (kef_action_e'(act_q))
        ACT_POP: begin
          // An empty queue answers with all fields clear.
          if (rp_q != wp_q) begin
            out_d.avail       = 1'b1;
            out_d.out_pressed = ev_rdata[EVENT_W-1];
            out_d.out_key     = ev_rdata[KEY_W-1:0];
            rp_d              = rp_next;
          end
        end
        ACT_SCANCODE: begin
          // Scancode zero, typematic repeats and stale releases change nothing.
          if (sc_q != SC_NONE && pressed != held) begin
            held_we = 1'b1;
            if (key != KC_NONE) begin
              if (wp_next == rp_q) begin
                out_d.event_dropped = 1'b1;
              end else begin
                ev_we              = 1'b1;
                wp_d               = wp_next;
                out_d.event_queued = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      held_vld_q  <= '0;
    end else begin
      busy_q <= in_xfer;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      if (held_we) begin
        held_vld_q[base] <= 1'b1;
      end
      if (busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_queued  = out_q.event_queued;
  assign out_o.event_dropped = out_q.event_dropped;
  assign out_o.avail         = out_q.avail;
  assign out_o.out_pressed   = out_q.out_pressed;
  assign out_o.out_key       = out_q.out_key;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("request stayed in flight for more than one cycle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q && out_valid_q == 1'b0)
    else $error("accepted request did not start or output register was full");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> out_valid_q)
    else $error("finished request produced no result");

  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.avail && (out_q.event_queued || out_q.event_dropped)))
    else $error("pop and scancode result fields both set");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_d != rp_q) |-> (rp_q != wp_q) && !ev_we)
    else $error("read pointer advanced on an empty queue");

endmodule
